/* design/ggfd_pkg.sv */
// shared constants, codes and types of the grid gradient finite difference unit
package ggfd_pkg;

  localparam int MAX_ROW_LENGTH = 1024;
  localparam int MAX_ROWS       = 4096;
  localparam int MAX_PLANES     = 8;
  localparam int SAMPLE_BITS    = 16;

  localparam int COL_W       = $clog2(MAX_ROW_LENGTH);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int PLANE_W     = $clog2(MAX_PLANES);
  localparam int ROW_LEN_W   = 11;
  localparam int ROW_CNT_W   = 13;
  localparam int PLANE_CNT_W = 4;

  localparam int SCALE_W     = ROW_W;
  localparam int DIFF_W      = SAMPLE_BITS + 2;
  localparam int PROD_W      = DIFF_W + SCALE_W + 1;
  localparam int SLOPE_W     = 28;
  localparam int SLOPE_LIMIT = 134084610;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ROW_CNT_W;
  localparam int OUT_DATA_W = 2 * SLOPE_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LENGTH  = 2'd0,
    CFG_ROW_COUNT   = 2'd1,
    CFG_PLANE_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIFF_FWD     = 2'd0,
    DIFF_BACK    = 2'd1,
    DIFF_CENTRAL = 2'd2
  } diff_mode_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // operands of one slope along one axis
  typedef struct packed {
    sample_t              behind;
    sample_t              here;
    sample_t              after;
    diff_mode_e           mode;
    logic [SCALE_W-1:0]   scale;
  } slope_req_t;

endpackage

/* design/ggfd_line_buf.sv */
// two row buffers: newer row written on accept, older row refilled from the newer row's read register
module ggfd_line_buf import ggfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_col_i,
  input  sample_t          wr_sample_i,
  input  logic             older_wr_en_i,
  input  logic [COL_W-1:0] older_wr_col_i,
  output sample_t          newer_here_o,
  output sample_t          newer_next_o,
  output sample_t          older_here_o
);

  sample_t newer_mem [MAX_ROW_LENGTH];
  sample_t older_mem [MAX_ROW_LENGTH];

  sample_t newer_here_q;
  sample_t newer_next_q;
  sample_t older_here_q;

  logic [COL_W-1:0] next_col;

  assign next_col = rd_col_i + COL_W'(1);

  // read before write on the newer row
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      newer_here_q        <= newer_mem[rd_col_i];
      newer_next_q        <= newer_mem[next_col];
      newer_mem[rd_col_i] <= wr_sample_i;
    end
  end

  // the row above moves down once the stage holds its value
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      older_here_q <= older_mem[rd_col_i];
    end
    if (older_wr_en_i) begin
      older_mem[older_wr_col_i] <= newer_here_q;
    end
  end

  assign newer_here_o = newer_here_q;
  assign newer_next_o = newer_next_q;
  assign older_here_o = older_here_q;

endmodule

/* design/ggfd_slope.sv */
// one-axis finite difference, scale multiply and saturation
module ggfd_slope import ggfd_pkg::*; (
  input  slope_req_t                 req_i,
  output logic signed [SLOPE_W-1:0]  slope_o
);

  logic signed [DIFF_W-1:0] before_x;
  logic signed [DIFF_W-1:0] here_x;
  logic signed [DIFF_W-1:0] after_x;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SCALE_W:0]  scale_x;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] lim_pos;
  logic signed [PROD_W-1:0] lim_neg;

  assign before_x = {{(DIFF_W-SAMPLE_BITS){req_i.behind[SAMPLE_BITS-1]}}, req_i.behind};
  assign here_x   = {{(DIFF_W-SAMPLE_BITS){req_i.here[SAMPLE_BITS-1]}}, req_i.here};
  assign after_x  = {{(DIFF_W-SAMPLE_BITS){req_i.after[SAMPLE_BITS-1]}}, req_i.after};
  assign scale_x  = {1'b0, req_i.scale};
  assign lim_pos  = PROD_W'(SLOPE_LIMIT);
  assign lim_neg  = -lim_pos;

  // one-sided differences count double in half-units
  always_comb begin
    case (req_i.mode)
      DIFF_FWD:     diff = (after_x - here_x) <<< 1;
      DIFF_BACK:    diff = (here_x - before_x) <<< 1;
      DIFF_CENTRAL: diff = after_x - before_x;
      default:      diff = '0;
    endcase
  end

  assign prod = diff * scale_x;

  always_comb begin
    if (prod > lim_pos) begin
      slope_o = lim_pos[SLOPE_W-1:0];
    end else if (prod < lim_neg) begin
      slope_o = lim_neg[SLOPE_W-1:0];
    end else begin
      slope_o = prod[SLOPE_W-1:0];
    end
  end

endmodule

/* design/grid_gradient_finite_difference_unit.sv */
// top level: counters, stage register, result sequencing and output register
// path: the word that completes a result is held in the stage register, its result then in the output register
// throughput: one word per cycle while the output is free and each word yields at most one result;
//   first-row words yield none; on the last row past column 0 two, the plane's last word three
// the shared slope pair forms one result per cycle from stage to a free output register
// reset: rst_ni clears counters, valids and config (row_length 2, row_count 2, plane_count 1);
//   row buffers are not cleared, every entry is written in a plane before it is used
module grid_gradient_finite_difference_unit import ggfd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // sample stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SAMPLE_BITS-1:0] s_axis_tdata,  // [15:0] sample
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [27:0] slope_across, [55:28] slope_along
  output logic                   m_axis_tlast,  // end_of_plane
  output logic                   m_axis_tuser   // end_of_set
);

  // stage register contents, one accepted word with its neighbors
  typedef struct packed {
    sample_t          sample;
    sample_t          prev;
    sample_t          prev2;
    sample_t          prev_mid;     // row above, one column back
    logic [COL_W-1:0] col;
    diff_mode_e       a_across_mode;
    diff_mode_e       a_along_mode;
    diff_mode_e       b_along_mode;
    logic             eos;
  } stage_t;

  // config registers
  logic [ROW_LEN_W-1:0]   row_length_q, row_length_d;
  logic [ROW_CNT_W-1:0]   row_count_q, row_count_d;
  logic [PLANE_CNT_W-1:0] plane_count_q, plane_count_d;
  logic                   cfg_hit;

  // position counters and recent samples
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  sample_t            prev_q, prev_d;
  sample_t            prev2_q, prev2_d;

  // stage
  stage_t     stage_q;
  logic       stage_valid_q, stage_valid_d;
  logic [2:0] pend_q, pend_d;
  logic [2:0] pend_after;

  // output register
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_last_q;
  logic                  out_user_q;
  logic                  out_valid_q, out_valid_d;

  // handshake and datapath
  logic                accept;
  logic                out_free;
  logic                out_load;
  logic                stage_done;
  logic                last_row;
  logic                col_last;
  logic [SCALE_W-1:0]  scale_across;
  logic [SCALE_W-1:0]  scale_along;
  sample_t             lb_newer_here;
  sample_t             lb_newer_next;
  sample_t             lb_older_here;
  slope_req_t          req_across;
  slope_req_t          req_along;
  logic signed [SLOPE_W-1:0] slope_across;
  logic signed [SLOPE_W-1:0] slope_along;
  logic                res_eop;
  logic                res_eos;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  // written values are clamped into the legal range
  always_comb begin
    row_length_d  = row_length_q;
    row_count_d   = row_count_q;
    plane_count_d = plane_count_q;
    cfg_hit       = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ROW_LENGTH: begin
          cfg_hit      = 1'b1;
          row_length_d = cfg_data_i[ROW_LEN_W-1:0];
          if (row_length_d < ROW_LEN_W'(2)) begin
            row_length_d = ROW_LEN_W'(2);
          end else if (row_length_d > ROW_LEN_W'(MAX_ROW_LENGTH)) begin
            row_length_d = ROW_LEN_W'(MAX_ROW_LENGTH);
          end
        end
        CFG_ROW_COUNT: begin
          cfg_hit     = 1'b1;
          row_count_d = cfg_data_i[ROW_CNT_W-1:0];
          if (row_count_d < ROW_CNT_W'(2)) begin
            row_count_d = ROW_CNT_W'(2);
          end else if (row_count_d > ROW_CNT_W'(MAX_ROWS)) begin
            row_count_d = ROW_CNT_W'(MAX_ROWS);
          end
        end
        CFG_PLANE_COUNT: begin
          cfg_hit       = 1'b1;
          plane_count_d = cfg_data_i[PLANE_CNT_W-1:0];
          if (plane_count_d < PLANE_CNT_W'(1)) begin
            plane_count_d = PLANE_CNT_W'(1);
          end else if (plane_count_d > PLANE_CNT_W'(MAX_PLANES)) begin
            plane_count_d = PLANE_CNT_W'(MAX_PLANES);
          end
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  // results leave the stage lowest pending first: row above, left neighbor, own point
  assign pend_after    = pend_q & (pend_q - 3'd1);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = stage_valid_q && (pend_q != 3'd0) && out_free;
  assign stage_done    = stage_valid_q && ((pend_q == 3'd0) || (out_load && pend_after == 3'd0));
  assign s_axis_tready = !stage_valid_q || stage_done;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- position
  assign last_row     = row_q == ROW_W'(row_count_q - ROW_CNT_W'(1));
  assign col_last     = col_q == COL_W'(row_length_q - ROW_LEN_W'(1));
  assign scale_across = SCALE_W'(row_count_q - ROW_CNT_W'(1));
  assign scale_along  = SCALE_W'(row_length_q - ROW_LEN_W'(1));

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    plane_d = plane_q;
    prev_d  = prev_q;
    prev2_d = prev2_q;
    if (cfg_hit) begin
      // any register write restarts the stream at the first point of plane 0
      col_d   = '0;
      row_d   = '0;
      plane_d = '0;
      prev_d  = '0;
      prev2_d = '0;
    end else if (accept) begin
      prev_d  = sample_t'(s_axis_tdata);
      prev2_d = prev_q;
      if (col_last) begin
        col_d = '0;
        if (last_row) begin
          row_d = '0;
          if (plane_q == PLANE_W'(plane_count_q - PLANE_CNT_W'(1))) begin
            plane_d = '0;
          end else begin
            plane_d = plane_q + PLANE_W'(1);
          end
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- stage control
  always_comb begin
    stage_valid_d = stage_valid_q;
    pend_d        = pend_q;
    if (accept) begin
      stage_valid_d = 1'b1;
      pend_d        = {last_row && col_last, last_row && (col_q != '0), row_q != '0};
    end else if (stage_done) begin
      stage_valid_d = 1'b0;
      pend_d        = '0;
    end else if (out_load) begin
      pend_d = pend_after;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q  <= ROW_LEN_W'(2);
      row_count_q   <= ROW_CNT_W'(2);
      plane_count_q <= PLANE_CNT_W'(1);
      col_q         <= '0;
      row_q         <= '0;
      plane_q       <= '0;
      prev_q        <= '0;
      prev2_q       <= '0;
      stage_valid_q <= 1'b0;
      pend_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      row_length_q  <= row_length_d;
      row_count_q   <= row_count_d;
      plane_count_q <= plane_count_d;
      col_q         <= col_d;
      row_q         <= row_d;
      plane_q       <= plane_d;
      prev_q        <= prev_d;
      prev2_q       <= prev2_d;
      stage_valid_q <= stage_valid_d;
      pend_q        <= pend_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // stage payload; the line buffer still shows the previous word's column
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q.sample   <= sample_t'(s_axis_tdata);
      stage_q.prev     <= prev_q;
      stage_q.prev2    <= prev2_q;
      stage_q.prev_mid <= lb_newer_here;
      stage_q.col      <= col_q;
      stage_q.eos      <= plane_q == PLANE_W'(plane_count_q - PLANE_CNT_W'(1));
      // across slope of the row above: forward on the first row, else central
      stage_q.a_across_mode <= (row_q == ROW_W'(1)) ? DIFF_FWD : DIFF_CENTRAL;
      if (col_q == '0) begin
        stage_q.a_along_mode <= DIFF_FWD;
      end else if (col_last) begin
        stage_q.a_along_mode <= DIFF_BACK;
      end else begin
        stage_q.a_along_mode <= DIFF_CENTRAL;
      end
      stage_q.b_along_mode <= (col_q == COL_W'(1)) ? DIFF_FWD : DIFF_CENTRAL;
    end
  end

  // ---------------------------------------------------------------- row buffers
  ggfd_line_buf u_line_buf (
    .clk_i          (clk_i),
    .rd_en_i        (accept),
    .rd_col_i       (col_q),
    .wr_sample_i    (sample_t'(s_axis_tdata)),
    .older_wr_en_i  (stage_valid_q),
    .older_wr_col_i (stage_q.col),
    .newer_here_o   (lb_newer_here),
    .newer_next_o   (lb_newer_next),
    .older_here_o   (lb_older_here)
  );

  // ---------------------------------------------------------------- operand select
  // last row points are always a backward difference across rows
  always_comb begin
    res_eop = 1'b0;
    res_eos = 1'b0;
    if (pend_q[0]) begin
      // point above the current word
      req_across = '{behind: lb_older_here, here: lb_newer_here, after: stage_q.sample,
                     mode: stage_q.a_across_mode, scale: scale_across};
      req_along  = '{behind: stage_q.prev_mid, here: lb_newer_here, after: lb_newer_next,
                     mode: stage_q.a_along_mode, scale: scale_along};
    end else if (pend_q[1]) begin
      // left neighbor on the last row
      req_across = '{behind: stage_q.prev_mid, here: stage_q.prev, after: '0,
                     mode: DIFF_BACK, scale: scale_across};
      req_along  = '{behind: stage_q.prev2, here: stage_q.prev, after: stage_q.sample,
                     mode: stage_q.b_along_mode, scale: scale_along};
    end else begin
      // last point of the plane
      req_across = '{behind: lb_newer_here, here: stage_q.sample, after: '0,
                     mode: DIFF_BACK, scale: scale_across};
      req_along  = '{behind: stage_q.prev, here: stage_q.sample, after: '0,
                     mode: DIFF_BACK, scale: scale_along};
      res_eop    = 1'b1;
      res_eos    = stage_q.eos;
    end
  end

  ggfd_slope u_slope_across (
    .req_i   (req_across),
    .slope_o (slope_across)
  );

  ggfd_slope u_slope_along (
    .req_i   (req_along),
    .slope_o (slope_along)
  );

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {slope_along, slope_across};
      out_last_q <= res_eop;
      out_user_q <= res_eos;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data_q);
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

endmodule
